FILE: hdl/tophist_pkg.sv
`timescale 1ns / 1ps

package tophist_pkg;

  localparam int ACTION_W = 3;
  localparam int TOKEN_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 16;

  localparam int MAP_DEPTH_DEF      = 64;
  localparam int POSITION_COUNT_DEF = 16;

  localparam logic [ACTION_W-1:0] ACT_NEW_PAIR    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_RIGHT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PROBE_LEFT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ_CELL   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_COUNT = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic signed [TOKEN_W-1:0] token;
    logic [POS_W-1:0]          pos;
  } map_entry_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

FILE: hdl/tophist_in_if.sv
`timescale 1ns / 1ps

interface tophist_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [tophist_pkg::ACTION_W-1:0]        action;
  logic signed [tophist_pkg::TOKEN_W-1:0]  token;
  logic [tophist_pkg::POS_W-1:0]           row_index;
  logic [tophist_pkg::POS_W-1:0]           col_index;

  modport source (output valid, action, token, row_index, col_index, input ready);
  modport sink (input valid, action, token, row_index, col_index, output ready);
endinterface

FILE: hdl/tophist_out_if.sv
`timescale 1ns / 1ps

interface tophist_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic                              map_full;
  logic [tophist_pkg::POS_W-1:0]     matched_col;
  logic [tophist_pkg::COUNT_W-1:0]   total_overlap;
  logic [tophist_pkg::COUNT_W-1:0]   cell_count;

  modport source (
    output valid, hit, map_full, matched_col, total_overlap, cell_count,
    input ready
  );
  modport sink (
    input valid, hit, map_full, matched_col, total_overlap, cell_count,
    output ready
  );
endinterface

FILE: hdl/token_overlap_position_histogram.sv
`timescale 1ns / 1ps
// load and probe scan the token map memory one entry per cycle; a probe hit with row
// and column in range then does a read-modify-write of the count memory, and read cell
// reads it; one transaction in flight at a time, the next is accepted while the last
// result waits in the output register
// reset clears the state, the fill count, the total, the cell valid bits, the output
// valid, pending and increment flags; no clearing pass, ready right after reset
module token_overlap_position_histogram #(
  parameter int MAP_DEPTH      = tophist_pkg::MAP_DEPTH_DEF,
  parameter int POSITION_COUNT = tophist_pkg::POSITION_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tophist_in_if.sink   in_i,
  tophist_out_if.source out_o
);

  localparam int FillW = $clog2(MAP_DEPTH + 1);
  localparam int MapAw = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int Cells = POSITION_COUNT * POSITION_COUNT;
  localparam int CellAw = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CW = tophist_pkg::COUNT_W;
  localparam int PW = tophist_pkg::POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_CUPD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [tophist_pkg::ACTION_W-1:0] act_q, act_d;
  logic [tophist_pkg::TOKEN_W-1:0] tok_q, tok_d;
  logic [PW-1:0] row_q, row_d, col_q, col_d;
  logic [FillW-1:0] fill_q, fill_d, scan_q, scan_d;
  logic [MapAw-1:0] cmp_q, cmp_d;
  logic pend_q, pend_d;
  logic [CW-1:0] total_q, total_d;
  logic [CellAw-1:0] caddr_q, caddr_d;
  logic inc_q, inc_d;
  logic [Cells-1:0] vld_q, vld_d;

  logic res_hit_q, res_hit_d, res_full_q, res_full_d;
  logic [PW-1:0] res_mcol_q, res_mcol_d;
  logic [CW-1:0] res_cell_q, res_cell_d;

  logic out_vld_q, out_vld_d;
  logic out_hit_q, out_hit_d, out_full_q, out_full_d;
  logic [PW-1:0] out_mcol_q, out_mcol_d;
  logic [CW-1:0] out_total_q, out_total_d, out_cell_q, out_cell_d;

  tophist_pkg::map_entry_t map_mem [MAP_DEPTH];
  tophist_pkg::map_entry_t map_rd_q, map_wdata;
  logic map_we;
  logic [MapAw-1:0] map_waddr;

  logic [CW-1:0] cnt_mem [Cells];
  logic [CW-1:0] cnt_rd_q, cnt_wdata, cnt_cur;
  logic cnt_we;

  logic in_acc, map_hit, row_ok, col_ok, in_row_ok, in_col_ok, pos_ok;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign map_hit = pend_q && (map_rd_q.token == tok_q);
  assign row_ok = {28'd0, row_q} < 32'(POSITION_COUNT);
  assign pos_ok = {28'd0, map_rd_q.pos} < 32'(POSITION_COUNT);
  assign in_row_ok = {28'd0, in_i.row_index} < 32'(POSITION_COUNT);
  assign in_col_ok = {28'd0, in_i.col_index} < 32'(POSITION_COUNT);
  assign col_ok = in_col_ok;
  assign cnt_cur = vld_q[caddr_q] ? cnt_rd_q : '0;

  always_comb begin
    state_d = state_q;
    act_d = act_q;
    tok_d = tok_q;
    row_d = row_q;
    col_d = col_q;
    fill_d = fill_q;
    scan_d = scan_q;
    cmp_d = cmp_q;
    pend_d = 1'b0;
    total_d = total_q;
    caddr_d = caddr_q;
    inc_d = inc_q;
    vld_d = vld_q;
    res_hit_d = res_hit_q;
    res_full_d = res_full_q;
    res_mcol_d = res_mcol_q;
    res_cell_d = res_cell_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_hit_d = out_hit_q;
    out_full_d = out_full_q;
    out_mcol_d = out_mcol_q;
    out_total_d = out_total_q;
    out_cell_d = out_cell_q;
    map_we = 1'b0;
    map_waddr = cmp_q;
    map_wdata = '{token: tok_q, pos: col_q};
    cnt_we = 1'b0;
    cnt_wdata = tophist_pkg::sat_inc(cnt_cur);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d = in_i.action;
          tok_d = in_i.token;
          row_d = in_i.row_index;
          col_d = in_i.col_index;
          res_hit_d = 1'b0;
          res_full_d = 1'b0;
          res_mcol_d = '0;
          res_cell_d = '0;
          scan_d = '0;
          caddr_d = CellAw'(32'(in_i.row_index) * 32'(POSITION_COUNT)
                            + 32'(in_i.col_index));
          inc_d = 1'b0;
          state_d = S_OUT;
          case (in_i.action)
            tophist_pkg::ACT_NEW_PAIR: fill_d = '0;
            tophist_pkg::ACT_LOAD_RIGHT, tophist_pkg::ACT_PROBE_LEFT: state_d = S_SCAN;
            tophist_pkg::ACT_READ_CELL: begin
              if (in_row_ok && col_ok) begin
                state_d = S_CRD;
              end
            end
            tophist_pkg::ACT_CLEAR_COUNT: begin
              vld_d = '0;
              total_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (map_hit) begin
          state_d = S_OUT;
          if (act_q == tophist_pkg::ACT_LOAD_RIGHT) begin
            map_we = 1'b1;
          end else begin
            res_hit_d = 1'b1;
            res_mcol_d = map_rd_q.pos;
            total_d = tophist_pkg::sat_inc(total_q);
            if (row_ok && pos_ok) begin
              caddr_d = CellAw'(32'(row_q) * 32'(POSITION_COUNT) + 32'(map_rd_q.pos));
              inc_d = 1'b1;
              state_d = S_CRD;
            end
          end
        end else if (scan_q == fill_q) begin
          state_d = S_OUT;
          if (act_q == tophist_pkg::ACT_LOAD_RIGHT) begin
            if (fill_q < FillW'(MAP_DEPTH)) begin
              map_we = 1'b1;
              map_waddr = fill_q[MapAw-1:0];
              fill_d = fill_q + FillW'(1);
            end else begin
              res_full_d = 1'b1;
            end
          end
        end else begin
          pend_d = 1'b1;
          cmp_d = scan_q[MapAw-1:0];
          scan_d = scan_q + FillW'(1);
        end
      end
      S_CRD: state_d = S_CUPD;
      S_CUPD: begin
        if (inc_q) begin
          cnt_we = 1'b1;
          vld_d[caddr_q] = 1'b1;
          res_cell_d = cnt_wdata;
        end else begin
          res_cell_d = cnt_cur;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_hit_d = res_hit_q;
          out_full_d = res_full_q;
          out_mcol_d = res_mcol_q;
          out_total_d = total_q;
          out_cell_d = res_cell_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      total_q <= '0;
      vld_q <= '0;
      pend_q <= 1'b0;
      out_vld_q <= 1'b0;
      inc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      total_q <= total_d;
      vld_q <= vld_d;
      pend_q <= pend_d;
      out_vld_q <= out_vld_d;
      inc_q <= inc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    tok_q <= tok_d;
    row_q <= row_d;
    col_q <= col_d;
    scan_q <= scan_d;
    cmp_q <= cmp_d;
    caddr_q <= caddr_d;
    res_hit_q <= res_hit_d;
    res_full_q <= res_full_d;
    res_mcol_q <= res_mcol_d;
    res_cell_q <= res_cell_d;
    out_hit_q <= out_hit_d;
    out_full_q <= out_full_d;
    out_mcol_q <= out_mcol_d;
    out_total_q <= out_total_d;
    out_cell_q <= out_cell_d;
  end

  // token map memory
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[scan_q[MapAw-1:0]];
  end

  // pair count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[caddr_q] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[caddr_q];
  end

  assign out_o.valid = out_vld_q;
  assign out_o.hit = out_hit_q;
  assign out_o.map_full = out_full_q;
  assign out_o.matched_col = out_mcol_q;
  assign out_o.total_overlap = out_total_q;
  assign out_o.cell_count = out_cell_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MAP_DEPTH))
    else $error("map fill beyond depth");

  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.hit && out_o.map_full))
    else $error("hit and map full in one transaction");

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && in_i.action == tophist_pkg::ACT_CLEAR_COUNT) |=> total_q >= $past(total_q))
    else $error("total dropped without clear");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accept did not start work");

endmodule

FILE: dv/token_overlap_position_histogram_test.sv
`timescale 1ns / 1ps

module token_overlap_position_histogram_test;

  localparam int MAP_SLOTS    = 64;
  localparam int POSITIONS    = 16;
  localparam int ITEM_TARGET  = 1500;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = MAP_SLOTS + 16;
  localparam int AW           = tophist_pkg::ACTION_W;
  localparam int TW           = tophist_pkg::TOKEN_W;
  localparam int PW           = tophist_pkg::POS_W;
  localparam int CW           = tophist_pkg::COUNT_W;

  typedef struct packed {
    logic          hit;
    logic          map_full;
    logic [PW-1:0] matched_col;
    logic [CW-1:0] total_overlap;
    logic [CW-1:0] cell_count;
  } hist_result_t;

  class overlap_scoreboard;
    bit [TW-1:0]  token_slot[MAP_SLOTS];
    bit [PW-1:0]  col_slot[MAP_SLOTS];
    int unsigned  fill;
    bit [CW-1:0]  cells[POSITIONS*POSITIONS];
    bit [CW-1:0]  total;
    hist_result_t pending_results[$];
    int unsigned  errors;

    function int find_slot(bit [TW-1:0] tok);
      for (int i = 0; i < fill; i++) begin
        if (token_slot[i] == tok) return i;
      end
      return -1;
    endfunction

    function bit [CW-1:0] bump(bit [CW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // note one accepted transaction and queue its expected result
    function void predict_action(logic [AW-1:0] act, logic [TW-1:0] tok,
                                 logic [PW-1:0] row, logic [PW-1:0] col);
      hist_result_t r;
      int slot;
      int addr;
      r = '0;
      slot = find_slot(tok);
      case (act)
        tophist_pkg::ACT_NEW_PAIR: fill = 0;
        tophist_pkg::ACT_LOAD_RIGHT: begin
          if (slot >= 0) begin
            col_slot[slot] = col;
          end else if (fill < MAP_SLOTS) begin
            token_slot[fill] = tok;
            col_slot[fill] = col;
            fill++;
          end else begin
            r.map_full = 1'b1;
          end
        end
        tophist_pkg::ACT_PROBE_LEFT: begin
          if (slot >= 0) begin
            r.hit = 1'b1;
            r.matched_col = col_slot[slot];
            total = bump(total);
            addr = int'(row) * POSITIONS + int'(col_slot[slot]);
            cells[addr] = bump(cells[addr]);
            r.cell_count = cells[addr];
          end
        end
        tophist_pkg::ACT_READ_CELL: r.cell_count = cells[int'(row) * POSITIONS + int'(col)];
        tophist_pkg::ACT_CLEAR_COUNT: begin
          foreach (cells[i]) cells[i] = '0;
          total = '0;
        end
        default: ;
      endcase
      r.total_overlap = total;
      pending_results.push_back(r);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(hist_result_t got);
      hist_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      report_field("hit", want.hit, got.hit);
      report_field("map_full", want.map_full, got.map_full);
      report_field("matched_col", want.matched_col, got.matched_col);
      report_field("total_overlap", want.total_overlap, got.total_overlap);
      report_field("cell_count", want.cell_count, got.cell_count);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   no_idle;
  int   items_sent;
  int   stall_cycles = 0;

  overlap_scoreboard sb = new();

  tophist_in_if  in_bus ();
  tophist_out_if out_bus ();

  token_overlap_position_histogram dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_bus.ready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) begin
      sb.compare_result({out_bus.hit, out_bus.map_full, out_bus.matched_col,
                         out_bus.total_overlap, out_bus.cell_count});
    end
    if (in_bus.valid && in_bus.ready) begin
      sb.predict_action(in_bus.action, in_bus.token, in_bus.row_index, in_bus.col_index);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("token_overlap_position_histogram regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [PW-1:0] rand_pos();
    return PW'($urandom_range(0, POSITIONS - 1));
  endfunction

  task automatic send_item(input logic [AW-1:0] act, input logic [TW-1:0] tok,
                           input logic [PW-1:0] row, input logic [PW-1:0] col);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 99) < 36) begin
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid     <= 1'b1;
        in_bus.action    <= act;
        in_bus.token     <= tok;
        in_bus.row_index <= row;
        in_bus.col_index <= col;
        placed = 1'b1;
      end
    end
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [TW-1:0] fresh_token(ref logic [TW-1:0] loaded[$]);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: return (loaded.size() > 0) ? loaded[$urandom_range(0, loaded.size() - 1)] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0) begin
      send_item(AW'($urandom_range(0, 7)), $urandom, rand_pos(), rand_pos());
    end
  endtask

  task automatic run_pair_session();
    int n_loads;
    int n_probes;
    logic [TW-1:0] tok;
    logic [TW-1:0] loaded[$];
    if ($urandom_range(0, 9) != 0) begin
      send_item(tophist_pkg::ACT_NEW_PAIR, $urandom, rand_pos(), rand_pos());
    end
    n_loads = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
    repeat (n_loads) begin
      maybe_noise();
      tok = fresh_token(loaded);
      send_item(tophist_pkg::ACT_LOAD_RIGHT, tok, rand_pos(), rand_pos());
      loaded.push_back(tok);
    end
    n_probes = $urandom_range(1, 24);
    repeat (n_probes) begin
      maybe_noise();
      if ($urandom_range(0, 9) < 7) tok = loaded[$urandom_range(0, loaded.size() - 1)];
      else tok = fresh_token(loaded);
      send_item(tophist_pkg::ACT_PROBE_LEFT, tok, rand_pos(), rand_pos());
    end
    repeat ($urandom_range(0, 4)) begin
      send_item(tophist_pkg::ACT_READ_CELL, $urandom, rand_pos(), rand_pos());
    end
    if ($urandom_range(0, 5) == 0) begin
      send_item(tophist_pkg::ACT_CLEAR_COUNT, $urandom, rand_pos(), rand_pos());
    end
  endtask

  initial begin
    int first_random;
    rst_ni           = 1'b0;
    no_idle          = 1'b0;
    items_sent       = 0;
    in_bus.valid     = 1'b0;
    in_bus.action    = tophist_pkg::ACT_NEW_PAIR;
    in_bus.token     = '0;
    in_bus.row_index = '0;
    in_bus.col_index = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_item(tophist_pkg::ACT_NEW_PAIR, '0, 4'd0, 4'd0);
    send_item(tophist_pkg::ACT_PROBE_LEFT, '0, 4'd0, 4'd0);
    send_item(tophist_pkg::ACT_LOAD_RIGHT, 32'h8000_0000, 4'd0, 4'd0);
    send_item(tophist_pkg::ACT_LOAD_RIGHT, 32'h7fff_ffff, 4'd15, 4'd15);
    send_item(tophist_pkg::ACT_LOAD_RIGHT, 32'h0000_0000, 4'd3, 4'd7);
    send_item(tophist_pkg::ACT_LOAD_RIGHT, 32'hffff_ffff, 4'd0, 4'd3);
    send_item(tophist_pkg::ACT_LOAD_RIGHT, 32'h7fff_ffff, 4'd0, 4'd9);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'h8000_0000, 4'd0, 4'd15);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'h7fff_ffff, 4'd15, 4'd0);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'hffff_ffff, 4'd15, 4'd15);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'h1234_5678, 4'd5, 4'd5);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'h0000_0000, 4'd5, 4'd0);
    send_item(tophist_pkg::ACT_READ_CELL, 32'hffff_ffff, 4'd15, 4'd9);
    send_item(tophist_pkg::ACT_READ_CELL, '0, 4'd0, 4'd0);
    send_item(tophist_pkg::ACT_READ_CELL, '0, 4'd15, 4'd15);
    send_item(tophist_pkg::ACT_READ_CELL, '0, 4'd0, 4'd15);
    send_item(3'd5, 32'hffff_ffff, 4'd15, 4'd15);
    send_item(3'd6, 32'h7fff_ffff, 4'd15, 4'd0);
    send_item(3'd7, 32'h8000_0000, 4'd0, 4'd15);
    send_item(tophist_pkg::ACT_CLEAR_COUNT, '0, 4'd0, 4'd0);
    send_item(tophist_pkg::ACT_READ_CELL, '0, 4'd15, 4'd9);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'h7fff_ffff, 4'd0, 4'd0);
    send_item(tophist_pkg::ACT_NEW_PAIR, 32'hffff_ffff, 4'd15, 4'd15);
    send_item(tophist_pkg::ACT_PROBE_LEFT, 32'h7fff_ffff, 4'd0, 4'd0);

    first_random = items_sent;
    while (items_sent < first_random + ITEM_TARGET) begin
      no_idle = (items_sent - first_random >= 600) && (items_sent - first_random < 900);
      run_pair_session();
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("token_overlap_position_histogram regression: pass");
    end else begin
      $display("token_overlap_position_histogram regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tophist_pkg.sv
hdl/tophist_in_if.sv
hdl/tophist_out_if.sv
hdl/token_overlap_position_histogram.sv
dv/token_overlap_position_histogram_test.sv
